FILE: hw/rtl/lr_pkg.sv
// lr_pkg: shared constants, types and helpers of the line rasterizer
// depends on nothing; imported by every rtl file of the block
`timescale 1ns / 1ps

package lr_pkg;

  // screen size
  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;

  // field widths
  localparam int unsigned XW = 7;
  localparam int unsigned YW = 6;
  // internal coordinate width, wide enough for either axis
  localparam int unsigned CW = (XW > YW) ? XW : YW;
  // error accumulator width: err + (dmin + 1) stays below 2 * 2^CW
  localparam int unsigned EW = CW + 1;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [CW-1:0] X_MAX = CW'(SCREEN_WIDTH - 1);
  localparam logic [CW-1:0] Y_MAX = CW'(SCREEN_HEIGHT - 1);

  typedef struct packed {
    logic [XW-1:0] first_x;
    logic [YW-1:0] first_y;
    logic [XW-1:0] second_x;
    logic [YW-1:0] second_y;
    logic          second_valid;
    logic          draw_value;
    logic          last;
  } lr_result_t;

  typedef struct packed {
    logic       valid;
    lr_result_t res;
  } lr_emit_t;

  typedef struct packed {
    logic [EW-1:0] err;
    logic          wrap;
  } lr_alu_out_t;

  function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] v,
                                                input logic [CW-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // absolute difference of two coordinates
  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: hw/rtl/lr_alu.sv
// lr_alu: error-term unit, one add and one compare-subtract per pixel
// depends on lr_pkg
`timescale 1ns / 1ps

module lr_alu (
  input  logic [lr_pkg::EW-1:0] err_i,
  input  logic [lr_pkg::EW-1:0] inc_i,
  input  logic [lr_pkg::EW-1:0] lim_i,
  output lr_pkg::lr_alu_out_t   res_o
);
  import lr_pkg::*;

  logic [EW-1:0] sum;

  assign sum        = err_i + inc_i;
  assign res_o.wrap = (sum >= lim_i);
  assign res_o.err  = res_o.wrap ? (sum - lim_i) : sum;

endmodule

FILE: hw/rtl/lr_ctrl.sv
// lr_ctrl: line sequencer, setup of deltas and endpoints, one pixel per step
// depends on lr_pkg and lr_alu
`timescale 1ns / 1ps

module lr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  logic [lr_pkg::CW-1:0] cmd_x1_i,
  input  logic [lr_pkg::CW-1:0] cmd_y1_i,
  input  logic [lr_pkg::CW-1:0] cmd_x2_i,
  input  logic [lr_pkg::CW-1:0] cmd_y2_i,
  input  logic                 cmd_value_i,
  output logic                 cmd_ready_o,
  input  logic                 out_free_i,
  output lr_pkg::lr_emit_t     emit_o
);
  import lr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;

  logic [1:0] state_q, state_d;

  // command registers
  logic [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic          value_q;

  // stepping registers
  logic          xmaj_q, xmaj_d;
  logic [CW-1:0] maj_q, maj_d, maj_end_q, maj_end_d;
  logic [CW-1:0] minor_q, minor_d;
  logic          dir_up_q, dir_up_d, dir_dn_q, dir_dn_d;
  logic [EW-1:0] inc_q, inc_d, lim_q, lim_d, err_q, err_d;
  logic          odd_q, odd_d;
  logic [CW-1:0] hold_x_q, hold_x_d, hold_y_q, hold_y_d;

  // setup logic
  logic [CW-1:0] dx, dy, s_maj0, s_maj1, s_min0, s_min1, s_dmaj, s_dmin;
  logic          s_xmaj, s_swap;
  logic [CW-1:0] b_min0, b_min1;

  always_comb begin
    dx     = abs_diff(x2_q, x1_q);
    dy     = abs_diff(y2_q, y1_q);
    s_xmaj = (dx >= dy);
    s_maj0 = s_xmaj ? x1_q : y1_q;
    s_maj1 = s_xmaj ? x2_q : y2_q;
    s_min0 = s_xmaj ? y1_q : x1_q;
    s_min1 = s_xmaj ? y2_q : x2_q;
    s_dmaj = s_xmaj ? dx : dy;
    s_dmin = s_xmaj ? dy : dx;
    s_swap = (s_maj0 > s_maj1);
    b_min0 = s_swap ? s_min1 : s_min0;
    b_min1 = s_swap ? s_min0 : s_min1;
  end

  // current pixel
  logic [CW-1:0] px, py;
  logic          is_end, need_emit, advance;
  lr_alu_out_t   alu;

  assign px = xmaj_q ? maj_q : minor_q;
  assign py = xmaj_q ? minor_q : maj_q;

  lr_alu u_alu (
    .err_i (err_q),
    .inc_i (inc_q),
    .lim_i (lim_q),
    .res_o (alu)
  );

  assign is_end    = (maj_q == maj_end_q);
  assign need_emit = odd_q | is_end;
  assign advance   = (state_q == ST_STEP) && (!need_emit || out_free_i);

  assign cmd_ready_o = (state_q == ST_IDLE);

  always_comb begin
    emit_o.valid            = (state_q == ST_STEP) && need_emit;
    emit_o.res.draw_value   = value_q;
    emit_o.res.last         = is_end;
    if (odd_q) begin
      emit_o.res.first_x      = hold_x_q[XW-1:0];
      emit_o.res.first_y      = hold_y_q[YW-1:0];
      emit_o.res.second_x     = px[XW-1:0];
      emit_o.res.second_y     = py[YW-1:0];
      emit_o.res.second_valid = 1'b1;
    end else begin
      emit_o.res.first_x      = px[XW-1:0];
      emit_o.res.first_y      = py[YW-1:0];
      emit_o.res.second_x     = '0;
      emit_o.res.second_y     = '0;
      emit_o.res.second_valid = 1'b0;
    end
  end

  always_comb begin
    state_d   = state_q;
    xmaj_d    = xmaj_q;
    maj_d     = maj_q;
    maj_end_d = maj_end_q;
    minor_d   = minor_q;
    dir_up_d  = dir_up_q;
    dir_dn_d  = dir_dn_q;
    inc_d     = inc_q;
    lim_d     = lim_q;
    err_d     = err_q;
    odd_d     = odd_q;
    hold_x_d  = hold_x_q;
    hold_y_d  = hold_y_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        xmaj_d    = s_xmaj;
        maj_d     = s_swap ? s_maj1 : s_maj0;
        maj_end_d = s_swap ? s_maj0 : s_maj1;
        minor_d   = b_min0;
        dir_up_d  = (b_min1 > b_min0);
        dir_dn_d  = (b_min1 < b_min0);
        inc_d     = {1'b0, s_dmin} + EW'(1);
        lim_d     = {1'b0, s_dmaj} + EW'(1);
        err_d     = '0;
        odd_d     = 1'b0;
        state_d   = ST_STEP;
      end
      ST_STEP: begin
        if (advance) begin
          if (!odd_q) begin
            hold_x_d = px;
            hold_y_d = py;
          end
          odd_d = ~odd_q;
          if (is_end) begin
            state_d = ST_IDLE;
          end else begin
            maj_d = maj_q + CW'(1);
            err_d = alu.err;
            if (alu.wrap) begin
              priority if (dir_up_q) begin
                minor_d = minor_q + CW'(1);
              end else if (dir_dn_q) begin
                minor_d = minor_q - CW'(1);
              end
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      x1_q    <= cmd_x1_i;
      y1_q    <= cmd_y1_i;
      x2_q    <= cmd_x2_i;
      y2_q    <= cmd_y2_i;
      value_q <= cmd_value_i;
    end
    xmaj_q    <= xmaj_d;
    maj_q     <= maj_d;
    maj_end_q <= maj_end_d;
    minor_q   <= minor_d;
    dir_up_q  <= dir_up_d;
    dir_dn_q  <= dir_dn_d;
    inc_q     <= inc_d;
    lim_q     <= lim_d;
    err_q     <= err_d;
    odd_q     <= odd_d;
    hold_x_q  <= hold_x_d;
    hold_y_q  <= hold_y_d;
  end

endmodule

FILE: hw/rtl/line_rasterizer_top.sv
// line_rasterizer_top: stream wrapper, input unpack and clamp, output register
// depends on lr_pkg, lr_ctrl (which holds lr_alu)
// sequence: accept in idle, a setup state, then the step state walks the major axis one pixel per
//   step and holds while a pair waits for the output register; a new command is taken only in idle
// a line of n pixels gives (n + 1) / 2 results
// reset: asynchronous active low, clears the sequencer state and the output valid
`timescale 1ns / 1ps

module line_rasterizer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x[6:0], start_y[12:7], end_x[19:13], end_y[25:20], pixel_on[26], zero fill
  input  logic [lr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // pixel pair stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // first_x[6:0], first_y[12:7], second_x[19:13], second_y[25:20], draw_value[26], zero fill
  output logic [lr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // second_valid[0]
  output logic                          m_axis_tuser,
  // last result of the line
  output logic                          m_axis_tlast
);
  import lr_pkg::*;

  // unpack and saturate the endpoints to the screen
  logic [XW-1:0] in_sx, in_ex;
  logic [YW-1:0] in_sy, in_ey;
  logic [CW-1:0] cx1, cy1, cx2, cy2;
  logic          in_value;

  assign in_sx    = s_axis_tdata[XW-1:0];
  assign in_sy    = s_axis_tdata[XW+YW-1:XW];
  assign in_ex    = s_axis_tdata[2*XW+YW-1:XW+YW];
  assign in_ey    = s_axis_tdata[2*XW+2*YW-1:2*XW+YW];
  assign in_value = s_axis_tdata[2*XW+2*YW];

  assign cx1 = clamp_coord(CW'(in_sx), X_MAX);
  assign cy1 = clamp_coord(CW'(in_sy), Y_MAX);
  assign cx2 = clamp_coord(CW'(in_ex), X_MAX);
  assign cy2 = clamp_coord(CW'(in_ey), Y_MAX);

  // output register decouples the sequencer from the sink
  logic       out_valid_q;
  lr_result_t out_q;
  logic       out_free;
  lr_emit_t   emit;

  assign out_free = !out_valid_q || m_axis_tready;

  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_x1_i    (cx1),
    .cmd_y1_i    (cy1),
    .cmd_x2_i    (cx2),
    .cmd_y2_i    (cy2),
    .cmd_value_i (in_value),
    .cmd_ready_o (s_axis_tready),
    .out_free_i  (out_free),
    .emit_o      (emit)
  );

  // valid bit of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  // payload of the output register, loaded when a pair transaction is produced
  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      out_q <= emit.res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2*XW - 2*YW - 1){1'b0}},
                          out_q.draw_value, out_q.second_y, out_q.second_x,
                          out_q.first_y, out_q.first_x};
  assign m_axis_tuser  = out_q.second_valid;
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: tb/tb_line_rasterizer_top.sv
// tb_line_rasterizer_top: self-checking testbench of the line rasterizer stream block
// predicts the pixel pairs of every accepted line command and compares them in order
// depends on lr_pkg and line_rasterizer_top only
`timescale 1ns / 1ps

module tb_line_rasterizer_top;

  import lr_pkg::*;

  // run limit in clock cycles, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  // cycles to wait after the last expected pair for stray output
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 10;

  // output tdata field positions, lowest bit first
  localparam int unsigned FX_LSB = 0;
  localparam int unsigned FY_LSB = XW;
  localparam int unsigned SX_LSB = XW + YW;
  localparam int unsigned SY_LSB = 2 * XW + YW;
  localparam int unsigned DV_BIT = 2 * XW + 2 * YW;

  typedef struct packed {
    logic [XW-1:0] start_x;
    logic [YW-1:0] start_y;
    logic [XW-1:0] end_x;
    logic [YW-1:0] end_y;
    logic          pixel_on;
  } line_cmd_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  // pixel pairs still owed by the block, oldest first
  lr_result_t  pair_q[$];
  int unsigned n_mismatch;
  int unsigned cycle_cnt;
  // idle percentages of sender and receiver, set per test
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // long receiver hold-off request, picked up by the ready process
  int unsigned rx_hold_req;

  line_rasterizer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog, ends a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pairs still expected", cycle_cnt,
               pair_q.size());
      $display("** line_rasterizer_top: FAILED **");
      $finish;
    end
  end

  // gap length: none most of the time, mostly short, now and then long
  function automatic int unsigned idle_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic void note_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endfunction

  // line stepping: swap so the major axis rises, error term gains minor delta + 1
  // per pixel and wraps at major delta + 1, pixels grouped in pairs
  function automatic void rasterize_line(input line_cmd_t c);
    int         x1, y1, x2, y2, d_x, d_y;
    int         maj_lo, maj_hi, min_lo, min_hi, d_maj, d_min, dir_minor;
    int         minor, acc, t, px, py, npix, tmp;
    bit         x_major;
    lr_result_t pair;
    // saturate to the screen
    x1 = (c.start_x > SCREEN_WIDTH - 1)  ? SCREEN_WIDTH - 1  : c.start_x;
    y1 = (c.start_y > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : c.start_y;
    x2 = (c.end_x > SCREEN_WIDTH - 1)    ? SCREEN_WIDTH - 1  : c.end_x;
    y2 = (c.end_y > SCREEN_HEIGHT - 1)   ? SCREEN_HEIGHT - 1 : c.end_y;
    d_x = (x2 >= x1) ? x2 - x1 : x1 - x2;
    d_y = (y2 >= y1) ? y2 - y1 : y1 - y2;
    x_major = (d_x >= d_y);
    if (x_major) begin
      maj_lo = x1; maj_hi = x2; min_lo = y1; min_hi = y2; d_maj = d_x; d_min = d_y;
    end else begin
      maj_lo = y1; maj_hi = y2; min_lo = x1; min_hi = x2; d_maj = d_y; d_min = d_x;
    end
    if (maj_lo > maj_hi) begin
      tmp = maj_lo; maj_lo = maj_hi; maj_hi = tmp;
      tmp = min_lo; min_lo = min_hi; min_hi = tmp;
    end
    dir_minor = (min_hi > min_lo) ? 1 : ((min_hi < min_lo) ? -1 : 0);
    minor = min_lo;
    acc   = 0;
    npix  = 0;
    pair  = '0;
    for (t = maj_lo; t <= maj_hi; t++) begin
      px = x_major ? t : minor;
      py = x_major ? minor : t;
      if (npix % 2 == 0) begin
        pair          = '0;
        pair.first_x  = XW'(px);
        pair.first_y  = YW'(py);
      end else begin
        pair.second_x     = XW'(px);
        pair.second_y     = YW'(py);
        pair.second_valid = 1'b1;
        pair.draw_value   = c.pixel_on;
        pair.last         = (t == maj_hi);
        pair_q.push_back(pair);
      end
      npix++;
      acc += d_min + 1;
      if (acc >= d_maj + 1) begin
        minor += dir_minor;
        acc   -= d_maj + 1;
      end
    end
    // odd pixel count: lone first pixel, second pixel zero and marked invalid
    if (npix % 2 == 1) begin
      pair.draw_value = c.pixel_on;
      pair.last       = 1'b1;
      pair_q.push_back(pair);
    end
  endfunction

  // one command transaction; valid stays high across back-to-back commands
  task automatic send_line(input line_cmd_t c);
    int unsigned gap;
    gap = idle_gap(tx_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 2 * XW - 2 * YW - 1){1'b0}}, c.pixel_on, c.end_y,
                      c.end_x, c.start_y, c.start_x};
    do @(posedge clk_i); while (!s_axis_tready);
    rasterize_line(c);
  endtask

  task automatic send_coords(input int sx, input int sy, input int ex, input int ey,
                             input bit on);
    line_cmd_t c;
    c.start_x  = XW'(sx);
    c.start_y  = YW'(sy);
    c.end_x    = XW'(ex);
    c.end_y    = YW'(ey);
    c.pixel_on = on;
    send_line(c);
  endtask

  // keep a coordinate near another one, inside the screen
  function automatic int near_coord(input int v, input int hi);
    int r;
    r = v + int'($urandom_range(12)) - 6;
    if (r < 0) r = 0;
    if (r > hi) r = hi;
    return r;
  endfunction

  // mix of short, axis-aligned, diagonal and fully random lines
  function automatic line_cmd_t random_line();
    line_cmd_t   c;
    int unsigned kind;
    int          sx, sy, k;
    sx         = $urandom_range(SCREEN_WIDTH - 1);
    sy         = $urandom_range(SCREEN_HEIGHT - 1);
    c.start_x  = XW'(sx);
    c.start_y  = YW'(sy);
    c.end_x    = XW'($urandom_range(SCREEN_WIDTH - 1));
    c.end_y    = YW'($urandom_range(SCREEN_HEIGHT - 1));
    c.pixel_on = $urandom_range(1);
    kind = $urandom_range(99);
    if (kind < 35) begin
      c.end_x = XW'(near_coord(sx, SCREEN_WIDTH - 1));
      c.end_y = YW'(near_coord(sy, SCREEN_HEIGHT - 1));
    end else if (kind < 43) begin
      c.end_y = c.start_y;
    end else if (kind < 50) begin
      c.end_x = c.start_x;
    end else if (kind < 58) begin
      // 45 degree line, either direction
      k = $urandom_range(SCREEN_HEIGHT - 1);
      c.end_x = XW'((sx + k > SCREEN_WIDTH - 1) ? sx - k : sx + k);
      c.end_y = YW'((sy + k > SCREEN_HEIGHT - 1) ? sy - k : sy + k);
      if (sx - k < 0 && sx + k > SCREEN_WIDTH - 1) c.end_x = c.start_x;
      if (sy - k < 0 && sy + k > SCREEN_HEIGHT - 1) c.end_y = c.start_y;
    end
    return c;
  endfunction

  // receiver ready: random stalls plus the long hold-off, counted here
  initial begin : rx_ready_gen
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0) begin
        stall_left = idle_gap(rx_idle_pct);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker, one pixel pair transaction per accepted beat
  always @(posedge clk_i) begin : pair_check
    lr_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.first_x      = m_axis_tdata[FX_LSB +: XW];
      got.first_y      = m_axis_tdata[FY_LSB +: YW];
      got.second_x     = m_axis_tdata[SX_LSB +: XW];
      got.second_y     = m_axis_tdata[SY_LSB +: YW];
      got.draw_value   = m_axis_tdata[DV_BIT];
      got.second_valid = m_axis_tuser;
      got.last         = m_axis_tlast;
      if (pair_q.size() == 0) begin
        note_mismatch($sformatf("unexpected pair (%0d,%0d) (%0d,%0d) sv=%0b dv=%0b last=%0b",
                                got.first_x, got.first_y, got.second_x, got.second_y,
                                got.second_valid, got.draw_value, got.last));
      end else begin
        want = pair_q.pop_front();
        if (got.first_x !== want.first_x || got.first_y !== want.first_y ||
            got.second_x !== want.second_x || got.second_y !== want.second_y ||
            got.second_valid !== want.second_valid ||
            got.draw_value !== want.draw_value || got.last !== want.last) begin
          note_mismatch($sformatf(
            {"expected (%0d,%0d) (%0d,%0d) sv=%0b dv=%0b last=%0b, ",
             "got (%0d,%0d) (%0d,%0d) sv=%0b dv=%0b last=%0b"},
            want.first_x, want.first_y, want.second_x, want.second_y, want.second_valid,
            want.draw_value, want.last, got.first_x, got.first_y, got.second_x,
            got.second_y, got.second_valid, got.draw_value, got.last));
        end
      end
    end
  end

  // zero-length lines at the screen corners, one pixel each
  task automatic test_single_pixels();
    send_coords(0, 0, 0, 0, 1'b1);
    send_coords(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 1'b0);
    send_coords(SCREEN_WIDTH - 1, 0, SCREEN_WIDTH - 1, 0, 1'b1);
  endtask

  // full-width and full-height lines, both directions; the longest gives the most pairs
  task automatic test_axis_lines();
    send_coords(0, 0, SCREEN_WIDTH - 1, 0, 1'b1);
    send_coords(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, SCREEN_HEIGHT - 1, 1'b0);
    send_coords(0, 0, 0, SCREEN_HEIGHT - 1, 1'b1);
    send_coords(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, SCREEN_WIDTH - 1, 0, 1'b0);
  endtask

  // diagonals, corner to corner, steep lines and the dx = dy tie
  task automatic test_diagonal_and_steep();
    send_coords(0, 0, SCREEN_HEIGHT - 1, SCREEN_HEIGHT - 1, 1'b1);
    send_coords(0, SCREEN_HEIGHT - 1, SCREEN_HEIGHT - 1, 0, 1'b0);
    send_coords(0, 0, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 1'b1);
    send_coords(SCREEN_WIDTH - 1, 0, 0, SCREEN_HEIGHT - 1, 1'b1);
    send_coords(10, 0, 3, SCREEN_HEIGHT - 1, 1'b0);
    send_coords(5, 5, 10, 11, 1'b1);
    send_coords(20, 20, 25, 25, 1'b0);
    send_coords(40, 30, 33, 37, 1'b1);
  endtask

  // odd pixel count leaves the second pixel empty; even count fills it
  task automatic test_pixel_count_parity();
    send_coords(0, 0, 1, 0, 1'b1);
    send_coords(0, 0, 2, 1, 1'b0);
    send_coords(7, 9, 7, 12, 1'b1);
    send_coords(7, 9, 7, 13, 1'b1);
    send_coords(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, SCREEN_WIDTH - 3, SCREEN_HEIGHT - 3, 1'b0);
  endtask

  // receiver holds off for a long stretch while commands keep coming
  task automatic test_receiver_holdoff();
    tx_idle_pct = 0;
    rx_hold_req = 400;
    repeat (12) send_line(random_line());
  endtask

  task automatic test_random_lines(input int unsigned n);
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    repeat (n) send_line(random_line());
  endtask

  // back-to-back commands, receiver always ready
  task automatic test_streaming_no_idle(input int unsigned n);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (n) send_line(random_line());
  endtask

  initial begin
    n_mismatch    = 0;
    cycle_cnt     = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rx_hold_req   = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pixels();
    test_axis_lines();
    test_diagonal_and_steep();
    test_pixel_count_parity();
    test_receiver_holdoff();
    test_random_lines(270);
    test_streaming_no_idle(80);
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray output
    rx_idle_pct = 20;
    while (pair_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_mismatch == 0) begin
      $display("** line_rasterizer_top: PASSED **");
    end else begin
      $display("** line_rasterizer_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: line_rasterizer_top.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_alu.sv
hw/rtl/lr_ctrl.sv
hw/rtl/line_rasterizer_top.sv
tb/tb_line_rasterizer_top.sv
